@@ rtl/tbo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tbo_pkg;

    // Box half extent registers
    localparam int HALF_WIDTH    = 23;
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic [HALF_WIDTH-1:0]    half_t;
    typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_HALF_X = 2'd0;
    localparam cfg_idx_t CFG_HALF_Y = 2'd1;
    localparam cfg_idx_t CFG_HALF_Z = 2'd2;

    localparam half_t HALF_RESET = 23'd128;

    // Reject codes
    localparam int REJECT_WIDTH = 4;

    typedef logic [REJECT_WIDTH-1:0] reject_t;

    localparam reject_t REJECT_NONE        = 4'd0;
    localparam reject_t REJECT_EDGE_BASE   = 4'd1;
    localparam reject_t REJECT_EXTENT_BASE = 4'd10;
    localparam reject_t REJECT_PLANE       = 4'd13;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Geometry
    localparam int NUM_AXES  = 3;
    localparam int NUM_VERTS = 3;
    localparam int NUM_EDGE_TESTS = 9;

endpackage

`default_nettype wire

@@ rtl/tbo_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tbo_queue #(
    parameter int DATA_WIDTH = 225
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic [DATA_WIDTH-1:0]      pop_data,
    output logic                       empty
);
    import tbo_pkg::*;

    logic [DATA_WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg,  count_next;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry on push
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("push into full queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

@@ rtl/tbo_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tbo_front #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [12*COORD_WIDTH-1:0]     in_coords,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [9*(COORD_WIDTH+1)-1:0]       q_data
);
    import tbo_pkg::*;

    localparam int VW = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] center [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] vert   [NUM_VERTS][NUM_AXES];

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Move vertices so the box centre is the origin
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            center[k] = $signed(in_coords[k*COORD_WIDTH +: COORD_WIDTH]);
        end
        for (int i = 0; i < NUM_VERTS; i++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                vert[i][k] = $signed(in_coords[(3+3*i+k)*COORD_WIDTH +: COORD_WIDTH]);
                q_data[(3*i+k)*VW +: VW] = VW'(vert[i][k]) - VW'(center[k]);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/tbo_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tbo_back #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [9*(COORD_WIDTH+1)-1:0]   q_data,
    input  wire logic                           q_empty,
    output logic                                q_pop,
    input  wire tbo_pkg::half_t                 half_x,
    input  wire tbo_pkg::half_t                 half_y,
    input  wire tbo_pkg::half_t                 half_z,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_overlaps,
    output tbo_pkg::reject_t                    m_reject_test
);
    import tbo_pkg::*;

    localparam int VW = COORD_WIDTH + 1;           // relative vertex
    localparam int EW = COORD_WIDTH + 2;           // edge
    localparam int HW = HALF_WIDTH;
    localparam int PW = EW + VW;                   // edge by vertex product
    localparam int RW = EW + HW + 1;               // radius
    localparam int CW = ((PW > RW) ? PW : RW) + 2; // edge axis compare width
    localparam int XW = ((VW > HW) ? VW : HW) + 2; // extent compare width
    localparam int MW = 2 * EW;                    // edge by edge product
    localparam int NW = MW + 1;                    // normal component
    localparam int NL = (NW + 1) / 2;              // normal low split
    localparam int NH = NW - NL;                   // normal high split
    localparam int FW = NW + ((VW > HW) ? VW : HW) + 4;
    localparam int STAGES = 7;

    // Stage control
    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES:0]   adv;

    always_comb begin
        adv[STAGES] = m_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? !q_empty : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign q_pop = !q_empty && adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    logic [HW-1:0] h [NUM_AXES];
    assign h[0] = half_x;
    assign h[1] = half_y;
    assign h[2] = half_z;

    // ---------------- stage 1: edges, edge magnitudes, extent tests
    logic signed [VW-1:0] vq [NUM_VERTS][NUM_AXES];
    logic signed [EW-1:0] e_pos [NUM_VERTS][NUM_AXES];
    logic signed [EW-1:0] e_neg [NUM_VERTS][NUM_AXES];
    logic [EW-1:0]        ea_next [NUM_VERTS][NUM_AXES];
    logic [NUM_AXES-1:0]  ext_next;
    logic signed [XW-1:0] vx, hx;
    logic                 all_hi, all_lo;

    logic signed [VW-1:0] s1_v_reg  [NUM_VERTS][NUM_AXES];
    logic signed [EW-1:0] s1_e_reg  [NUM_VERTS][NUM_AXES];
    logic [EW-1:0]        s1_ea_reg [NUM_VERTS][NUM_AXES];
    logic [NUM_AXES-1:0]  s1_ext_reg;

    always_comb begin
        for (int i = 0; i < NUM_VERTS; i++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                vq[i][k] = $signed(q_data[(3*i+k)*VW +: VW]);
            end
        end
        for (int i = 0; i < NUM_VERTS; i++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                e_pos[i][k] = EW'(vq[(i == 2) ? 0 : i+1][k]) - EW'(vq[i][k]);
                e_neg[i][k] = EW'(vq[i][k]) - EW'(vq[(i == 2) ? 0 : i+1][k]);
                ea_next[i][k] = e_pos[i][k][EW-1] ? e_neg[i][k] : e_pos[i][k];
            end
        end
        // separated on a box axis when all vertices lie beyond one face
        for (int k = 0; k < NUM_AXES; k++) begin
            all_hi = 1'b1;
            all_lo = 1'b1;
            hx = $signed(XW'(h[k]));
            for (int i = 0; i < NUM_VERTS; i++) begin
                vx = XW'(vq[i][k]);
                if (!(vx > hx)) begin
                    all_hi = 1'b0;
                end
                if (!((vx + hx) < 0)) begin
                    all_lo = 1'b0;
                end
            end
            ext_next[k] = all_hi || all_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_v_reg   <= vq;
            s1_e_reg   <= e_pos;
            s1_ea_reg  <= ea_next;
            s1_ext_reg <= ext_next;
        end
    end

    // ---------------- stage 2: products
    logic signed [PW-1:0] pa0_next [NUM_EDGE_TESTS];
    logic signed [PW-1:0] pb0_next [NUM_EDGE_TESTS];
    logic signed [PW-1:0] pa1_next [NUM_EDGE_TESTS];
    logic signed [PW-1:0] pb1_next [NUM_EDGE_TESTS];
    logic [RW-2:0]        ra_next  [NUM_EDGE_TESTS];
    logic [RW-2:0]        rb_next  [NUM_EDGE_TESTS];
    logic signed [MW-1:0] nm_next  [NUM_AXES][2];
    int                   ca, cb, i0, i1, t, k1, k2;

    logic signed [PW-1:0] s2_pa0_reg [NUM_EDGE_TESTS];
    logic signed [PW-1:0] s2_pb0_reg [NUM_EDGE_TESTS];
    logic signed [PW-1:0] s2_pa1_reg [NUM_EDGE_TESTS];
    logic signed [PW-1:0] s2_pb1_reg [NUM_EDGE_TESTS];
    logic [RW-2:0]        s2_ra_reg  [NUM_EDGE_TESTS];
    logic [RW-2:0]        s2_rb_reg  [NUM_EDGE_TESTS];
    logic signed [MW-1:0] s2_nm_reg  [NUM_AXES][2];
    logic signed [VW-1:0] s2_v0_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]  s2_ext_reg;

    always_comb begin
        for (int i = 0; i < NUM_VERTS; i++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                // axis is edge i crossed with box axis j
                t  = 3 * i + j;
                ca = (j == 2) ? 1 : 2;
                cb = (j == 0) ? 1 : 0;
                i0 = (j == 2) ? ((i == 1) ? 0 : 1) : 0;
                i1 = (j == 2) ? ((i == 1) ? 1 : 2) : ((i == 2) ? 1 : 2);
                pa0_next[t] = s1_e_reg[i][ca] * s1_v_reg[i0][cb];
                pb0_next[t] = s1_e_reg[i][cb] * s1_v_reg[i0][ca];
                pa1_next[t] = s1_e_reg[i][ca] * s1_v_reg[i1][cb];
                pb1_next[t] = s1_e_reg[i][cb] * s1_v_reg[i1][ca];
                ra_next[t]  = s1_ea_reg[i][ca] * h[cb];
                rb_next[t]  = s1_ea_reg[i][cb] * h[ca];
            end
        end
        // normal = edge0 x edge1
        for (int k = 0; k < NUM_AXES; k++) begin
            k1 = (k == 2) ? 0 : k + 1;
            k2 = (k == 0) ? 2 : k - 1;
            nm_next[k][0] = s1_e_reg[0][k1] * s1_e_reg[1][k2];
            nm_next[k][1] = s1_e_reg[0][k2] * s1_e_reg[1][k1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_pa0_reg <= pa0_next;
            s2_pb0_reg <= pb0_next;
            s2_pa1_reg <= pa1_next;
            s2_pb1_reg <= pb1_next;
            s2_ra_reg  <= ra_next;
            s2_rb_reg  <= rb_next;
            s2_nm_reg  <= nm_next;
            s2_v0_reg  <= s1_v_reg[0];
            s2_ext_reg <= s1_ext_reg;
        end
    end

    // ---------------- stage 3: projections, radii, normal
    logic signed [CW-1:0] p0_next  [NUM_EDGE_TESTS];
    logic signed [CW-1:0] p1_next  [NUM_EDGE_TESTS];
    logic signed [CW-1:0] rad_next [NUM_EDGE_TESTS];
    logic signed [NW-1:0] n_pos [NUM_AXES];
    logic signed [NW-1:0] n_neg [NUM_AXES];
    logic [NW-1:0]        na_next [NUM_AXES];

    logic signed [CW-1:0] s3_p0_reg  [NUM_EDGE_TESTS];
    logic signed [CW-1:0] s3_p1_reg  [NUM_EDGE_TESTS];
    logic signed [CW-1:0] s3_rad_reg [NUM_EDGE_TESTS];
    logic signed [NW-1:0] s3_n_reg   [NUM_AXES];
    logic [NW-1:0]        s3_na_reg  [NUM_AXES];
    logic signed [VW-1:0] s3_v0_reg  [NUM_AXES];
    logic [NUM_AXES-1:0]  s3_ext_reg;

    always_comb begin
        for (int n = 0; n < NUM_EDGE_TESTS; n++) begin
            p0_next[n]  = CW'(s2_pa0_reg[n]) - CW'(s2_pb0_reg[n]);
            p1_next[n]  = CW'(s2_pa1_reg[n]) - CW'(s2_pb1_reg[n]);
            rad_next[n] = $signed(CW'(s2_ra_reg[n])) + $signed(CW'(s2_rb_reg[n]));
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            n_pos[k]   = NW'(s2_nm_reg[k][0]) - NW'(s2_nm_reg[k][1]);
            n_neg[k]   = NW'(s2_nm_reg[k][1]) - NW'(s2_nm_reg[k][0]);
            na_next[k] = n_pos[k][NW-1] ? n_neg[k] : n_pos[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_p0_reg  <= p0_next;
            s3_p1_reg  <= p1_next;
            s3_rad_reg <= rad_next;
            s3_n_reg   <= n_pos;
            s3_na_reg  <= na_next;
            s3_v0_reg  <= s2_v0_reg;
            s3_ext_reg <= s2_ext_reg;
        end
    end

    // ---------------- stage 4: edge compares, plane partial products
    logic [NUM_EDGE_TESTS-1:0] edge_next;
    logic signed [NL+VW:0]     dlo_next [NUM_AXES];
    logic signed [NH+VW-1:0]   dhi_next [NUM_AXES];
    logic [NL+HW-1:0]          rlo_next [NUM_AXES];
    logic [NH+HW-1:0]          rhi_next [NUM_AXES];

    logic [NUM_EDGE_TESTS-1:0] s4_edge_reg;
    logic signed [NL+VW:0]     s4_dlo_reg [NUM_AXES];
    logic signed [NH+VW-1:0]   s4_dhi_reg [NUM_AXES];
    logic [NL+HW-1:0]          s4_rlo_reg [NUM_AXES];
    logic [NH+HW-1:0]          s4_rhi_reg [NUM_AXES];
    logic [NUM_AXES-1:0]       s4_ext_reg;

    always_comb begin
        // separated when both projections lie beyond the radius on one side
        for (int n = 0; n < NUM_EDGE_TESTS; n++) begin
            edge_next[n] =
                ((s3_p0_reg[n] > s3_rad_reg[n]) && (s3_p1_reg[n] > s3_rad_reg[n])) ||
                (((s3_p0_reg[n] + s3_rad_reg[n]) < 0) &&
                 ((s3_p1_reg[n] + s3_rad_reg[n]) < 0));
        end
        for (int k = 0; k < NUM_AXES; k++) begin
            dlo_next[k] = $signed({1'b0, s3_n_reg[k][NL-1:0]}) * s3_v0_reg[k];
            dhi_next[k] = $signed(s3_n_reg[k][NW-1:NL]) * s3_v0_reg[k];
            rlo_next[k] = s3_na_reg[k][NL-1:0] * h[k];
            rhi_next[k] = s3_na_reg[k][NW-1:NL] * h[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_edge_reg <= edge_next;
            s4_dlo_reg  <= dlo_next;
            s4_dhi_reg  <= dhi_next;
            s4_rlo_reg  <= rlo_next;
            s4_rhi_reg  <= rhi_next;
            s4_ext_reg  <= s3_ext_reg;
        end
    end

    // ---------------- stage 5: join partial products
    logic signed [FW-1:0] d_next [NUM_AXES];
    logic signed [FW-1:0] r_next [NUM_AXES];

    logic signed [FW-1:0]      s5_d_reg [NUM_AXES];
    logic signed [FW-1:0]      s5_r_reg [NUM_AXES];
    logic [NUM_EDGE_TESTS-1:0] s5_edge_reg;
    logic [NUM_AXES-1:0]       s5_ext_reg;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            d_next[k] = (FW'(s4_dhi_reg[k]) <<< NL) + FW'(s4_dlo_reg[k]);
            r_next[k] = $signed((FW'(s4_rhi_reg[k]) << NL) + FW'(s4_rlo_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_d_reg    <= d_next;
            s5_r_reg    <= r_next;
            s5_edge_reg <= s4_edge_reg;
            s5_ext_reg  <= s4_ext_reg;
        end
    end

    // ---------------- stage 6: plane offset and radius sums
    logic signed [FW-1:0]      s6_dsum_reg, dsum_next;
    logic signed [FW-1:0]      s6_rsum_reg, rsum_next;
    logic [NUM_EDGE_TESTS-1:0] s6_edge_reg;
    logic [NUM_AXES-1:0]       s6_ext_reg;

    assign dsum_next = s5_d_reg[0] + s5_d_reg[1] + s5_d_reg[2];
    assign rsum_next = s5_r_reg[0] + s5_r_reg[1] + s5_r_reg[2];

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s6_dsum_reg <= dsum_next;
            s6_rsum_reg <= rsum_next;
            s6_edge_reg <= s5_edge_reg;
            s6_ext_reg  <= s5_ext_reg;
        end
    end

    // ---------------- stage 7: plane test and first failing test
    logic    plane_fail;
    reject_t reject_next;
    logic    m_overlaps_reg;
    reject_t m_reject_reg;

    always_comb begin
        plane_fail  = ((s6_dsum_reg + s6_rsum_reg) < 0) ||
                      ((s6_rsum_reg - s6_dsum_reg) < 0);
        reject_next = REJECT_NONE;
        if (plane_fail) begin
            reject_next = REJECT_PLANE;
        end
        // later tests first so the earliest failure wins
        for (int k = NUM_AXES - 1; k >= 0; k--) begin
            if (s6_ext_reg[k]) begin
                reject_next = REJECT_EXTENT_BASE + REJECT_WIDTH'(k);
            end
        end
        for (int n = NUM_EDGE_TESTS - 1; n >= 0; n--) begin
            if (s6_edge_reg[n]) begin
                reject_next = REJECT_EDGE_BASE + REJECT_WIDTH'(n);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            m_overlaps_reg <= (reject_next == REJECT_NONE);
            m_reject_reg   <= reject_next;
        end
    end

    assign m_valid       = vld_reg[STAGES-1];
    assign m_overlaps    = m_overlaps_reg;
    assign m_reject_test = m_reject_reg;

    a_overlap_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_overlaps == (m_reject_test == REJECT_NONE)))
        else $error("overlap flag disagrees with reject code");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reject_test <= REJECT_PLANE))
        else $error("reject code out of range");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/triangle_box_overlap_test.sv @@
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | box centre, vertices a, b, c (x, y, z)
// m_       | out       | m_valid / m_ready  | overlaps, reject_test
// cfg_     | in        | cfg_we             | cfg_addr, cfg_wdata (box half extents)
//
// One item per cycle sustained while m_ready stays high.
// The front writes relative vertices into a 4-entry queue; a 7-stage back end with
// at most one multiplier level per stage does the thirteen axis tests.
// Reset is synchronous and active low; half extents reset to 0.5 (128).
// A stall on m_ready holds the back end; the queue keeps s_ready high until it fills.
`timescale 1ns / 1ps
`default_nettype none

module triangle_box_overlap_test #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire tbo_pkg::cfg_idx_t             cfg_addr,
    input  wire tbo_pkg::half_t                cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_center_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] s_vertex_c_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_overlaps,
    output tbo_pkg::reject_t                   m_reject_test
);
    import tbo_pkg::*;

    localparam int QW = 9 * (COORD_WIDTH + 1);

    half_t half_x_reg, half_y_reg, half_z_reg;

    // Write half extents; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_x_reg <= HALF_RESET;
            half_y_reg <= HALF_RESET;
            half_z_reg <= HALF_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HALF_X: half_x_reg <= cfg_wdata;
                CFG_HALF_Y: half_y_reg <= cfg_wdata;
                CFG_HALF_Z: half_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [12*COORD_WIDTH-1:0] in_coords;
    logic                      q_push, q_full, q_pop, q_empty;
    logic [QW-1:0]             q_wdata, q_rdata;

    assign in_coords = {s_vertex_c_z, s_vertex_c_y, s_vertex_c_x,
                        s_vertex_b_z, s_vertex_b_y, s_vertex_b_x,
                        s_vertex_a_z, s_vertex_a_y, s_vertex_a_x,
                        s_center_z,   s_center_y,   s_center_x};

    tbo_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_coords (in_coords),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    tbo_queue #(.DATA_WIDTH(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    tbo_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_data        (q_rdata),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .half_x        (half_x_reg),
        .half_y        (half_y_reg),
        .half_z        (half_z_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_overlaps    (m_overlaps),
        .m_reject_test (m_reject_test)
    );

endmodule

`default_nettype wire
